// ----- sv/lcdn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, codes and pin-state tables for the character LCD 4-bit
// write sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // Command codes carried by an input word.
    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_INSTR  = 3'd1,
        CMD_CHAR   = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_e;

    // Row base addresses for cursor moves.
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;
    localparam logic [7:0] ROW2_BASE = 8'h94;
    localparam logic [7:0] ROW3_BASE = 8'hD4;

    // Power-up setup instructions and wake-up nibbles.
    localparam logic [7:0] INIT_FUNC_SET  = 8'h28;
    localparam logic [7:0] INIT_DISP_ON   = 8'h0C;
    localparam logic [7:0] INIT_ENTRY     = 8'h06;
    localparam logic [7:0] INSTR_CLEAR    = 8'h01;
    localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;

    // Step counter covers the longest run (init, 25 states).
    localparam int STEP_W        = 5;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd24;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd3;
    localparam logic [STEP_W-1:0] INIT_BYTE_START = 5'd9;
    localparam logic [STEP_W-1:0] INIT_WAKE_LAST  = 5'd6;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Hold times in milliseconds.
    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_SHORT = 2'd1;
    localparam logic [1:0] HOLD_LONG  = 2'd2;

    // One classified job as the back carries it out.
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic       long_last;
        logic [7:0] data;
    } job_t;

    // Push request from the front into the queue.
    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    // One pin state of a run.
    typedef struct packed {
        logic       rs_level;
        logic       enable_level;
        logic [3:0] data_nibble;
        logic [1:0] hold_ms;
        logic       last;
    } pin_state_t;

    // Pin state at a given step of the power-up init run.
    function automatic pin_state_t init_state(input logic [STEP_W-1:0] step);
        pin_state_t        s;
        logic [STEP_W-1:0] k;
        logic [7:0]        b;
        s.rs_level     = 1'b0;
        s.enable_level = 1'b0;
        s.data_nibble  = 4'h0;
        s.hold_ms      = HOLD_SHORT;
        s.last         = (step == INIT_LAST_STEP);
        k              = step - INIT_BYTE_START;
        case (k[3:2])
            2'd0:    b = INIT_FUNC_SET;
            2'd1:    b = INIT_DISP_ON;
            2'd2:    b = INIT_ENTRY;
            default: b = INSTR_CLEAR;
        endcase
        if (step == '0)
        begin
            // Set-up state with all pins low and no hold.
            s.hold_ms = HOLD_NONE;
        end
        else if (step < INIT_BYTE_START)
        begin
            // Three wake-up strobes, then the switch to 4-bit mode.
            s.enable_level = step[0];
            s.data_nibble  = (step <= INIT_WAKE_LAST) ? WAKE_NIBBLE : FOUR_BIT_NIBBLE;
        end
        else
        begin
            s.enable_level = ~k[0];
            s.data_nibble  = k[1] ? b[3:0] : b[7:4];
        end
        return s;
    endfunction

endpackage

// ----- sv/lcdn_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_cmd_if
// Command channel: one word per display command.
// ----------------------------------------------------------------------------
interface lcdn_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] value;
    logic [7:0] column;
    logic [1:0] row;

    modport source (output valid, command, value, column, row, input ready);
    modport sink   (input valid, command, value, column, row, output ready);
endinterface

// ----- sv/lcdn_pin_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_pin_if
// Pin-state channel: one word per LCD bus state.
// ----------------------------------------------------------------------------
interface lcdn_pin_if;
    logic       valid;
    logic       ready;
    logic       rs_level;
    logic       enable_level;
    logic [3:0] data_nibble;
    logic [1:0] hold_ms;
    logic       last;

    modport source (output valid, rs_level, enable_level, data_nibble, hold_ms, last,
                    input ready);
    modport sink   (input valid, rs_level, enable_level, data_nibble, hold_ms, last,
                    output ready);
endinterface

// ----- sv/lcdn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts command words and turns each into a job: the byte to send, the
// register-select level and the run flavor. Undefined codes are dropped.
// ----------------------------------------------------------------------------
module lcdn_front (
    lcdn_cmd_if.sink          cmd,
    input  logic              queue_full,
    output lcdn_pkg::job_push_t push
);
    import lcdn_pkg::*;

    logic [7:0] row_base;
    logic       accept;

    // Take a word whenever the queue has room.
    assign cmd.ready = ~queue_full;
    assign accept    = cmd.valid & cmd.ready;

    // Row base address lookup for cursor moves.
    always_comb
    begin
        case (cmd.row)
            2'd0:    row_base = ROW0_BASE;
            2'd1:    row_base = ROW1_BASE;
            2'd2:    row_base = ROW2_BASE;
            default: row_base = ROW3_BASE;
        endcase
    end

    // Classify the command into a job.
    always_comb
    begin
        push.valid         = 1'b0;
        push.job.is_init   = 1'b0;
        push.job.rs        = 1'b0;
        push.job.long_last = 1'b0;
        push.job.data      = cmd.value;
        case (cmd.command)
            CMD_INIT:
            begin
                push.valid       = accept;
                push.job.is_init = 1'b1;
            end
            CMD_INSTR:
            begin
                push.valid = accept;
            end
            CMD_CHAR:
            begin
                push.valid  = accept;
                push.job.rs = 1'b1;
            end
            CMD_CURSOR:
            begin
                push.valid    = accept;
                push.job.data = row_base + cmd.column;
            end
            CMD_CLEAR:
            begin
                push.valid         = accept;
                push.job.long_last = 1'b1;
                push.job.data      = INSTR_CLEAR;
            end
            default:
            begin
                push.valid = 1'b0;
            end
        endcase
    end
endmodule

// ----- sv/lcdn_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_queue
// Two-entry job queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module lcdn_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  lcdn_pkg::job_push_t push,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output lcdn_pkg::job_t      head
);
    import lcdn_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_pop;

    assign full      = (count_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_pop    = pop & not_empty;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.valid);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.job;
        end
    end
endmodule

// ----- sv/lcdn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_back
// Steps through the pin states of the job at the queue head, one state per
// cycle while the pin channel takes them, into a registered output stage.
// ----------------------------------------------------------------------------
module lcdn_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  lcdn_pkg::job_t job,
    output logic           pop,
    lcdn_pin_if.source     pins
);
    import lcdn_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pin_state_t        out_reg;
    pin_state_t        out_next;
    pin_state_t        byte_state;
    pin_state_t        cur_state;
    logic              advance;
    logic              emit;

    // Pin state for a plain byte: high nibble, then low, each strobed.
    always_comb
    begin
        byte_state.rs_level     = job.rs;
        byte_state.enable_level = ~step_reg[0];
        byte_state.data_nibble  = step_reg[1] ? job.data[3:0] : job.data[7:4];
        byte_state.last         = (step_reg == BYTE_LAST_STEP);
        byte_state.hold_ms      = (byte_state.last && job.long_last) ? HOLD_LONG
                                                                     : HOLD_SHORT;
        cur_state = job.is_init ? init_state(step_reg) : byte_state;
    end

    // The output stage moves when empty or when its word is taken.
    assign advance = ~out_valid_reg | pins.ready;
    assign emit    = advance & job_valid;
    assign pop     = emit & cur_state.last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = cur_state;
            step_next      = cur_state.last ? '0 : step_reg + 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Drive the pin channel from the output stage.
    assign pins.valid        = out_valid_reg;
    assign pins.rs_level     = out_reg.rs_level;
    assign pins.enable_level = out_reg.enable_level;
    assign pins.data_nibble  = out_reg.data_nibble;
    assign pins.hold_ms      = out_reg.hold_ms;
    assign pins.last         = out_reg.last;
endmodule

// ----- sv/char_lcd_nibble_write_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns display commands into runs of 4-bit LCD bus pin states.
//
//   channel  dir  words               fields
//   cmd      in   one per command     command, value, column, row
//   pins     out  one per bus state   rs_level, enable_level, data_nibble,
//                                     hold_ms, last
//
// The back emits one pin state per cycle while the pin channel does not stall,
// so an ordinary command gives four pin states and a power-up init gives 25;
// undefined codes are accepted and give nothing. A two-entry job queue lets
// new commands arrive while a run is in progress. Reset empties the queue and
// the output stage. A stall on the pin channel holds the current state and,
// once the queue fills, the command channel.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    lcdn_cmd_if.sink   cmd,
    lcdn_pin_if.source pins
);
    import lcdn_pkg::*;

    job_push_t push;
    job_t      head;
    logic      queue_full;
    logic      queue_not_empty;
    logic      pop;

    // Front: accept and classify.
    lcdn_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push)
    );

    // Job queue between front and back.
    lcdn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // Back: pin-state sequencing.
    lcdn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head),
        .pop       (pop),
        .pins      (pins)
    );
endmodule
